// ===== hdl/htd_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// htd_pkg
// Shared types and constants for the depth/age replacing transposition table.
// -----------------------------------------------------------------------------
package htd_pkg;

  // Slot count; must be a power of two, the slot index is the low key bits.
  localparam int unsigned TABLE_ENTRIES = 65536;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned FLAG_W  = 2;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned MOVE_W  = 16;
  localparam int unsigned AGE_W   = 4;
  localparam int unsigned ACT_W   = 2;

  localparam logic [AGE_W-1:0] FRESH_AGE_RST = 4'd2;
  localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(TABLE_ENTRIES - 1);

  // in_tdata: key, bound_flag, search_depth, score, best_move -> 106 bits, padded
  localparam int unsigned IN_DATA_W  = 112;
  // out_tdata: found_flag, found_depth, found_score, found_move -> 42 bits, padded
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PROBE = 2'd0,
    ACT_STORE = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_WIPE,
    ST_IDLE,
    ST_LOOK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [AGE_W-1:0]          age;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [FLAG_W-1:0]         flag;
    logic [KEY_W-1:0]          key;
  } entry_t;

  typedef struct packed {
    action_t                   action;
    logic [KEY_W-1:0]          key;
    logic [FLAG_W-1:0]         flag;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic                      written;
    logic [FLAG_W-1:0]         flag;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
  } result_t;

  typedef struct packed {
    logic    we;
    entry_t  wentry;
    result_t res;
  } upd_t;

endpackage
`default_nettype wire

// ===== hdl/hash_table_depth_age_replace.sv =====
`default_nettype none
// Probe/store: the request is registered with its RAM read, then the result is
//   loaded into the output register once the output is free. A new probe or store
//   is accepted only after the RAM read and then the write-back of the same slot.
// Clear: a sweep writing one slot per cycle, then an all-zero result once the output is free.
// Reset: a sweep writes all TABLE_ENTRIES slots empty with age 2; no
//   request is accepted until it ends, configuration writes are taken.
// -----------------------------------------------------------------------------
// hash_table_depth_age_replace
// Direct-mapped transposition table with depth-preferred, aging replacement.
// -----------------------------------------------------------------------------
module hash_table_depth_age_replace (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [htd_pkg::AGE_W-1:0]         cfg_data,   // fresh_age
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // key[63:0], bound_flag[65:64], search_depth[73:66], score[89:74],
  // best_move[105:90], zero pad
  input  wire logic [htd_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic [htd_pkg::ACT_W-1:0]         in_tuser,   // action
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // found_flag[1:0], found_depth[9:2], found_score[25:10], found_move[41:26],
  // zero pad
  output logic [htd_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic [htd_pkg::OUT_USER_W-1:0]         out_tuser   // hit[0], written[1]
);

  import htd_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] wipe_cnt_r, wipe_cnt_nxt;
  logic [AGE_W-1:0] wipe_age_r, wipe_age_nxt;
  logic             owe_r, owe_nxt;
  logic [AGE_W-1:0] fresh_age_r;
  req_t             req_r;
  req_t             in_req;
  logic             in_acc;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t           rd_entry;
  entry_t           wipe_entry;
  upd_t             upd;

  logic             out_free;
  logic             load_out;
  result_t          out_res_nxt;
  logic             out_valid_r;
  result_t          out_res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_age_r <= FRESH_AGE_RST;
    end else if (cfg_valid) begin
      fresh_age_r <= cfg_data;
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_req.action = action_t'(in_tuser);
    in_req.key    = in_tdata[63:0];
    in_req.flag   = in_tdata[65:64];
    in_req.depth  = in_tdata[73:66];
    in_req.score  = in_tdata[89:74];
    in_req.move   = in_tdata[105:90];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_req;
    end
  end

  htd_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_req.key[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  htd_update u_update (
    .req       (req_r),
    .rd        (rd_entry),
    .fresh_age (fresh_age_r),
    .upd       (upd)
  );

  always_comb begin
    wipe_entry     = '0;
    wipe_entry.age = wipe_age_r;
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    wipe_cnt_nxt = wipe_cnt_r;
    wipe_age_nxt = wipe_age_r;
    owe_nxt      = owe_r;
    ram_we       = 1'b0;
    ram_waddr    = req_r.key[IDX_W-1:0];
    ram_wdata    = upd.wentry;
    load_out     = 1'b0;
    out_res_nxt  = upd.res;
    unique case (state_r)
      ST_WIPE: begin
        ram_we       = 1'b1;
        ram_waddr    = wipe_cnt_r;
        ram_wdata    = wipe_entry;
        wipe_cnt_nxt = wipe_cnt_r + IDX_W'(1);
        if (wipe_cnt_r == IDX_LAST) begin
          state_nxt = owe_r ? ST_DONE : ST_IDLE;
          owe_nxt   = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (req_r.action == ACT_CLEAR) begin
          state_nxt    = ST_WIPE;
          wipe_cnt_nxt = '0;
          wipe_age_nxt = fresh_age_r;
          owe_nxt      = 1'b1;
        end else if (out_free) begin
          ram_we    = upd.we;
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        // clear result is all zero
        out_res_nxt = '0;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_WIPE;
      wipe_cnt_r <= '0;
      wipe_age_r <= FRESH_AGE_RST;
      owe_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wipe_cnt_r <= wipe_cnt_nxt;
      wipe_age_r <= wipe_age_nxt;
      owe_r      <= owe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_res_r.written, out_res_r.hit};
  assign out_tdata  = {(OUT_DATA_W - 42)'(0), out_res_r.move, out_res_r.score,
                       out_res_r.depth, out_res_r.flag};

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("RAM written while idle");

  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_LOOK))
    else $error("accepted request did not enter lookup");

  a_wipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WIPE && state_nxt == ST_WIPE) |=>
      (wipe_cnt_r == $past(wipe_cnt_r) + IDX_W'(1)))
    else $error("clear sweep skipped a slot");

  a_store_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK && req_r.action == ACT_STORE && out_free) |-> ram_we)
    else $error("store finished without write-back");

  a_hit_xor_written: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.hit && out_res_r.written))
    else $error("result flags both hit and written");

endmodule
`default_nettype wire

// ===== hdl/htd_ram.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// htd_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// -----------------------------------------------------------------------------
module htd_ram #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned WIDTH = 110,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/htd_update.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// htd_update
// Read-modify-write datapath: probe match, store age/depth replacement.
// -----------------------------------------------------------------------------
module htd_update (
  input  wire htd_pkg::req_t            req,
  input  wire htd_pkg::entry_t          rd,
  input  wire logic [htd_pkg::AGE_W-1:0] fresh_age,
  output htd_pkg::upd_t                 upd
);

  import htd_pkg::*;

  logic [AGE_W-1:0] age_dec;
  logic             replace;

  always_comb begin
    // saturate at zero
    age_dec = (rd.age == '0) ? '0 : rd.age - AGE_W'(1);
    replace = (req.depth >= rd.depth) || (age_dec == '0);

    upd        = '0;
    upd.wentry = rd;
    unique case (req.action)
      ACT_PROBE: begin
        if (rd.key == req.key) begin
          upd.res.hit   = 1'b1;
          upd.res.flag  = rd.flag;
          upd.res.depth = rd.depth;
          upd.res.score = rd.score;
          upd.res.move  = rd.move;
        end
      end
      ACT_STORE: begin
        // write back even when kept: the lowered age must stick
        upd.we          = 1'b1;
        upd.res.written = replace;
        if (replace) begin
          upd.wentry.key   = req.key;
          upd.wentry.flag  = req.flag;
          upd.wentry.depth = req.depth;
          upd.wentry.score = req.score;
          upd.wentry.move  = req.move;
          upd.wentry.age   = fresh_age;
        end else begin
          upd.wentry.age = age_dec;
        end
      end
      ACT_CLEAR, ACT_NONE: begin
        upd.we = 1'b0;
      end
      default: begin
        upd.we = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire
